FILE: design/coalescing_status_queue_assert.svh
// ----------------------------------------------------------------------------
// coalescing_status_queue_assert.svh
// Assertion macros used by the coalescing status queue checker
// ----------------------------------------------------------------------------
`ifndef COALESCING_STATUS_QUEUE_ASSERT_SVH
`define COALESCING_STATUS_QUEUE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CSQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/csq_pkg.sv
// ----------------------------------------------------------------------------
// csq_pkg
// Types, widths and codes of the coalescing status queue
// ----------------------------------------------------------------------------
package csq_pkg;

  // field widths
  localparam int ID_W     = 16;
  localparam int STAMP_W  = 32;
  localparam int TAKE_W   = 6;
  localparam int STATUS_W = 3;
  localparam int QCOUNT_W = 6;

  // sizing defaults
  localparam int QUEUE_DEPTH_DEF   = 32;
  localparam int STAMP_ENTRIES_DEF = 128;

  // most results a single drain may produce
  localparam int MAX_RESULTS = 32;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_DRAIN  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_APPENDED = 3'd0,
    ST_MERGED   = 3'd1,
    ST_STALE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_DRAINED  = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_IDX,
    S_READ,
    S_CHECK,
    S_DRAIN
  } state_t;

  // broadcast command to every cell of the chain
  typedef struct packed {
    logic            shift;
    logic            append;
    logic            merge;
    logic [ID_W-1:0] id;
    logic            flag;
  } cell_cmd_t;

  // what the chain reports back to the sequencer
  typedef struct packed {
    logic            hit;
    logic [ID_W-1:0] head_id;
    logic            head_flag;
  } chain_stat_t;

endpackage

FILE: design/csq_ifs.sv
// ----------------------------------------------------------------------------
// csq_ifs
// Valid/ready channels carrying update/drain items in and results out
// ----------------------------------------------------------------------------

// input channel
interface csq_in_if;
  logic                      valid;
  logic                      ready;
  csq_pkg::op_t              op;
  logic [csq_pkg::ID_W-1:0]    slot_id;
  logic [csq_pkg::STAMP_W-1:0] stamp;
  logic                      slot_free;
  logic [csq_pkg::TAKE_W-1:0]  take_count;

  modport source (output valid, op, slot_id, stamp, slot_free, take_count, input ready);
  modport sink   (input valid, op, slot_id, stamp, slot_free, take_count, output ready);
endinterface

// result channel
interface csq_out_if;
  logic                         valid;
  logic                         ready;
  csq_pkg::status_t             status;
  logic [csq_pkg::ID_W-1:0]     out_slot_id;
  logic                         out_slot_free;
  logic                         last;
  logic [csq_pkg::QCOUNT_W-1:0] queue_count;

  modport source (output valid, status, out_slot_id, out_slot_free, last, queue_count,
                  input ready);
  modport sink   (input valid, status, out_slot_id, out_slot_free, last, queue_count,
                  output ready);
endinterface

FILE: design/csq_cell.sv
// ----------------------------------------------------------------------------
// csq_cell
// One queue position: holds an id and a free flag, matches the broadcast id
// ----------------------------------------------------------------------------
module csq_cell (
  input  logic                     clk,
  input  csq_pkg::cell_cmd_t       cmd,
  input  logic                     in_use,
  input  logic                     at_tail,
  input  logic [csq_pkg::ID_W-1:0] nb_id,
  input  logic                     nb_flag,
  output logic [csq_pkg::ID_W-1:0] id,
  output logic                     flag,
  output logic                     hit
);

  logic [csq_pkg::ID_W-1:0] id_r;
  logic                     flag_r;

  // occupied position holding the broadcast id
  assign hit  = in_use && (id_r == cmd.id);
  assign id   = id_r;
  assign flag = flag_r;

  // shift toward the head, load at the tail, or overwrite the flag on a match
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      id_r   <= nb_id;
      flag_r <= nb_flag;
    end else if (cmd.append && at_tail) begin
      id_r   <= cmd.id;
      flag_r <= cmd.flag;
    end else if (cmd.merge && hit) begin
      flag_r <= cmd.flag;
    end
  end

endmodule

FILE: design/csq_chain.sv
// ----------------------------------------------------------------------------
// csq_chain
// Row of queue cells; position zero is always the oldest entry
// ----------------------------------------------------------------------------
module csq_chain #(
  parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk,
  input  csq_pkg::cell_cmd_t   cmd,
  input  logic [CNT_W-1:0]     count,
  output csq_pkg::chain_stat_t stat
);

  logic [csq_pkg::ID_W-1:0] id_a   [QUEUE_DEPTH];
  logic                     flag_a [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   hit_v;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [csq_pkg::ID_W-1:0] nb_id;
    logic                     nb_flag;

    // neighbor toward the tail; the last cell takes its own contents
    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign nb_id   = id_a[i];
      assign nb_flag = flag_a[i];
    end else begin : g_mid
      assign nb_id   = id_a[i+1];
      assign nb_flag = flag_a[i+1];
    end

    csq_cell u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .in_use  (CNT_W'(i) < count),
      .at_tail (CNT_W'(i) == count),
      .nb_id   (nb_id),
      .nb_flag (nb_flag),
      .id      (id_a[i]),
      .flag    (flag_a[i]),
      .hit     (hit_v[i])
    );
  end

  // ids in the queue are unique, so at most one cell hits
  assign stat.hit       = |hit_v;
  assign stat.head_id   = id_a[0];
  assign stat.head_flag = flag_a[0];

endmodule

FILE: design/coalescing_status_queue.sv
// ----------------------------------------------------------------------------
// coalescing_status_queue
// Ordered queue of slot status updates that merges repeats per slot
// ----------------------------------------------------------------------------
// One item is worked on at a time. An update runs from acceptance until
// the next item can be accepted through these steps: S_MOD and S_IDX
// reduce the slot id modulo STAMP_ENTRIES through a reciprocal multiply,
// S_READ reads the timestamp memory, and S_CHECK compares stamps, matches
// the id across all queue cells and writes back. A drain of n results has
// one entry leave the head cell per cycle as the chain shifts, while the
// sink takes results; a drain of an empty queue gives a single empty
// result even with a zero take count, and a zero take count on a
// non-empty queue gives no result. Results sit in an output register, so
// a stalled sink holds up the queue. After reset the timestamp memory is
// zeroed by a clearing pass during which no item is accepted. queue_count
// shows the low six bits of the held count.
// ----------------------------------------------------------------------------
module coalescing_status_queue #(
  parameter int QUEUE_DEPTH   = csq_pkg::QUEUE_DEPTH_DEF,
  parameter int STAMP_ENTRIES = csq_pkg::STAMP_ENTRIES_DEF
) (
  input logic      clk,
  input logic      rst_n,
  csq_in_if.sink   in_ch,
  csq_out_if.source out_ch
);

  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W  = $clog2(STAMP_ENTRIES);
  localparam int ID_W    = csq_pkg::ID_W;
  localparam int STAMP_W = csq_pkg::STAMP_W;
  localparam int NRES_W  = csq_pkg::NRES_W;
  localparam int CMP_W   = (CNT_W > csq_pkg::TAKE_W) ? CNT_W : csq_pkg::TAKE_W;
  // reciprocal for exact division of a 16 bit id by STAMP_ENTRIES
  localparam int RSHIFT  = ID_W + SLOT_W;
  localparam longint unsigned RECIP =
    ((64'd1 << RSHIFT) + STAMP_ENTRIES - 1) / STAMP_ENTRIES;
  localparam int RECIP_W = ID_W + 2;

  csq_pkg::state_t state_r, state_nxt;

  logic [ID_W-1:0]       id_r;
  logic [STAMP_W-1:0]    stamp_r;
  logic                  free_r;
  logic [ID_W-1:0]       quot_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [SLOT_W-1:0]     clr_r;
  logic [STAMP_W-1:0]    rd_stamp_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [NRES_W-1:0]     nleft_r, nleft_nxt;

  logic                  out_valid_r;
  csq_pkg::status_t      out_status_r;
  logic [ID_W-1:0]       out_id_r;
  logic                  out_free_r;
  logic                  out_last_r;
  logic [csq_pkg::QCOUNT_W-1:0] out_count_r;

  logic [STAMP_W-1:0]    stamp_mem [STAMP_ENTRIES];

  logic                  in_fire;
  logic                  out_room;
  logic                  emit;
  csq_pkg::status_t      res_status;
  logic [ID_W-1:0]       res_id;
  logic                  res_free;
  logic                  res_last;
  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_waddr;
  logic [STAMP_W-1:0]    mem_wdata;
  csq_pkg::cell_cmd_t    cmd;
  csq_pkg::chain_stat_t  stat;

  logic [ID_W+RECIP_W-1:0] prod;
  logic [ID_W-1:0]         rem;
  logic [CMP_W-1:0]        take_cap;

  assign in_ch.ready = (state_r == csq_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_room    = !out_valid_r || out_ch.ready;

  // queue cells
  csq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk   (clk),
    .cmd   (cmd),
    .count (count_r),
    .stat  (stat)
  );

  // modulo: quotient by reciprocal, then remainder with one correction
  assign prod = (ID_W + RECIP_W)'(id_r) * (ID_W + RECIP_W)'(RECIP);

  always_comb begin
    rem = id_r - ID_W'(quot_r * ID_W'(STAMP_ENTRIES));
    if (rem >= ID_W'(STAMP_ENTRIES)) begin
      rem = rem - ID_W'(STAMP_ENTRIES);
    end
  end

  // drain length limited by the result cap and the held count
  always_comb begin
    take_cap = CMP_W'(in_ch.take_count);
    if (take_cap > CMP_W'(csq_pkg::MAX_RESULTS)) begin
      take_cap = CMP_W'(csq_pkg::MAX_RESULTS);
    end
    if (take_cap > CMP_W'(count_r)) begin
      take_cap = CMP_W'(count_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      csq_pkg::S_CLEAR: begin
        if (clr_r == SLOT_W'(STAMP_ENTRIES - 1)) state_nxt = csq_pkg::S_IDLE;
      end
      csq_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.op == csq_pkg::OP_UPDATE) begin
            state_nxt = csq_pkg::S_MOD;
          end else if ((in_ch.take_count != '0) || (count_r == '0)) begin
            state_nxt = csq_pkg::S_DRAIN;
          end
        end
      end
      csq_pkg::S_MOD:   state_nxt = csq_pkg::S_IDX;
      csq_pkg::S_IDX:   state_nxt = csq_pkg::S_READ;
      csq_pkg::S_READ:  state_nxt = csq_pkg::S_CHECK;
      csq_pkg::S_CHECK: begin
        if (out_room) state_nxt = csq_pkg::S_IDLE;
      end
      csq_pkg::S_DRAIN: begin
        if (out_room && (nleft_r <= NRES_W'(1))) state_nxt = csq_pkg::S_IDLE;
      end
      default: state_nxt = csq_pkg::S_CLEAR;
    endcase
  end

  // datapath control and results
  always_comb begin
    emit       = 1'b0;
    res_status = csq_pkg::ST_APPENDED;
    res_id     = id_r;
    res_free   = free_r;
    res_last   = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = slot_r;
    mem_wdata  = stamp_r;
    count_nxt  = count_r;
    nleft_nxt  = nleft_r;
    cmd        = '{shift: 1'b0, append: 1'b0, merge: 1'b0, id: id_r, flag: free_r};
    case (state_r)
      csq_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      csq_pkg::S_IDLE: begin
        if (in_fire && (in_ch.op == csq_pkg::OP_DRAIN)) begin
          nleft_nxt = NRES_W'(take_cap);
        end
      end
      csq_pkg::S_CHECK: begin
        if (out_room) begin
          emit = 1'b1;
          if (rd_stamp_r > stamp_r) begin
            res_status = csq_pkg::ST_STALE;
          end else if (stat.hit) begin
            res_status = csq_pkg::ST_MERGED;
            cmd.merge  = 1'b1;
            mem_we     = 1'b1;
          end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
            res_status = csq_pkg::ST_FULL;
          end else begin
            res_status = csq_pkg::ST_APPENDED;
            cmd.append = 1'b1;
            mem_we     = 1'b1;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
      end
      csq_pkg::S_DRAIN: begin
        if (out_room) begin
          emit = 1'b1;
          if (nleft_r == '0) begin
            res_status = csq_pkg::ST_EMPTY;
            res_id     = '0;
            res_free   = 1'b0;
          end else begin
            res_status = csq_pkg::ST_DRAINED;
            res_id     = stat.head_id;
            res_free   = stat.head_flag;
            res_last   = (nleft_r == NRES_W'(1));
            cmd.shift  = 1'b1;
            count_nxt  = count_r - CNT_W'(1);
            nleft_nxt  = nleft_r - NRES_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csq_pkg::S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      nleft_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      nleft_r <= nleft_nxt;
      if (state_r == csq_pkg::S_CLEAR) clr_r <= clr_r + SLOT_W'(1);
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item hold, modulo stages and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      id_r    <= in_ch.slot_id;
      stamp_r <= in_ch.stamp;
      free_r  <= in_ch.slot_free;
    end
    if (state_r == csq_pkg::S_MOD) quot_r <= ID_W'(prod >> RSHIFT);
    if (state_r == csq_pkg::S_IDX) slot_r <= SLOT_W'(rem);
    if (emit) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_free_r   <= res_free;
      out_last_r   <= res_last;
      out_count_r  <= csq_pkg::QCOUNT_W'(count_nxt);
    end
  end

  // last timestamp memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) stamp_mem[mem_waddr] <= mem_wdata;
    if (state_r == csq_pkg::S_READ) rd_stamp_r <= stamp_mem[slot_r];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.out_slot_id   = out_id_r;
  assign out_ch.out_slot_free = out_free_r;
  assign out_ch.last          = out_last_r;
  assign out_ch.queue_count   = out_count_r;

endmodule

FILE: design/csq_checker.sv
// ----------------------------------------------------------------------------
// csq_checker
// Port-level assertions for the coalescing status queue, bound to the top
// ----------------------------------------------------------------------------
`include "coalescing_status_queue_assert.svh"

module csq_checker #(
  parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input csq_pkg::status_t             out_status,
  input logic                         out_last,
  input logic [csq_pkg::QCOUNT_W-1:0] out_queue_count
);

  // a stalled result stays offered
  `CSQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // not ready for an item when reset is released, as the clearing pass runs
  `CSQ_ASSERT_NOW(a_clear_busy, clk, rst_n, $rose(rst_n), !in_ready, "item accepted during clear")

  // the reported count never exceeds the queue size
  `CSQ_ASSERT_NOW(a_count_max, clk, rst_n, out_valid, int'(out_queue_count) <= QUEUE_DEPTH, "count above depth")

  // every non-drain result closes its item
  `CSQ_ASSERT_NOW(a_single_last, clk, rst_n, out_valid && (out_status != csq_pkg::ST_DRAINED), out_last, "single result without last")

  // draining the final entry must end the drain
  `CSQ_ASSERT_NOW(a_drain_end, clk, rst_n, out_valid && (out_status == csq_pkg::ST_DRAINED) && (out_queue_count == '0) && (QUEUE_DEPTH < 64), out_last, "drain continues past empty queue")

endmodule

bind coalescing_status_queue csq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_csq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_last        (out_ch.last),
  .out_queue_count (out_ch.queue_count)
);
